>>> rtl/cnis_pkg.sv
// ----------------------------------------------------------------------------
// cnis_pkg
// Payload types and fixed constants of the normal contact impulse solver.
// ----------------------------------------------------------------------------
package cnis_pkg;

   localparam int NORMAL_FRAC = 14;
   localparam int QUO_BITS    = 32;

   typedef struct packed {
      logic [47:0]        contact_normal;
      logic signed [31:0] a_vel_x;
      logic signed [31:0] a_vel_y;
      logic signed [31:0] a_vel_z;
      logic signed [31:0] b_vel_x;
      logic signed [31:0] b_vel_y;
      logic signed [31:0] b_vel_z;
      logic [30:0]        mass_denominator;
      logic signed [31:0] target_normal_velocity;
      logic [30:0]        accumulated_impulse;
      logic [63:0]        inverse_masses;
      logic               last_contact;
   } req_payload_type;

   typedef struct packed {
      logic signed [31:0] new_a_vel_x;
      logic signed [31:0] new_a_vel_y;
      logic signed [31:0] new_a_vel_z;
      logic signed [31:0] new_b_vel_x;
      logic signed [31:0] new_b_vel_y;
      logic signed [31:0] new_b_vel_z;
      logic [30:0]        new_accumulated_impulse;
      logic               zero_denominator;
      logic               last_contact_out;
   } rsp_payload_type;

   typedef struct packed {
      logic [2:0][15:0] n;
      logic [2:0][31:0] va;
      logic [2:0][31:0] vb;
      logic [30:0]      k;
      logic [30:0]      jn0;
      logic [31:0]      ima;
      logic [31:0]      imb;
      logic             last;
   } ctx_type;

endpackage

>>> rtl/cnis_stream_if.sv
// ----------------------------------------------------------------------------
// cnis_stream_if
// Valid/ready stream channel carrying one payload per transaction.
// ----------------------------------------------------------------------------
interface cnis_stream_if #(parameter type payload_type = logic);
   logic        valid;
   logic        ready;
   payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

>>> rtl/contact_normal_impulse_solve_core.sv
// ----------------------------------------------------------------------------
// contact_normal_impulse_solve_core
// Pipelined sequential-impulse normal contact solve with restoring divider.
// ----------------------------------------------------------------------------
//   channel   dir  transaction
//   req_chan  in   one contact: normal, velocities, k, target, impulse, masses
//   rsp_chan  out  one result: new velocities, impulse, zero-k flag, last mark
//
// One transaction per cycle sustained while rsp_chan is not stalled.
// The restoring divider has 32 stages, one quotient bit a stage.
// Reset clears the stage valid bits only; no clearing pass.
// A stalled rsp freezes every stage at once; req_chan.ready follows it.
// ----------------------------------------------------------------------------
module contact_normal_impulse_solve_core
   import cnis_pkg::*;
#(
   parameter int FRAC_BITS = 16
) (
   input  logic          clock,
   input  logic          reset,
   cnis_stream_if.sink   req_chan,
   cnis_stream_if.source rsp_chan
);

   localparam int NUM_W = 38;
   localparam int M_W   = NUM_W + FRAC_BITS;
   localparam int DIV_N = QUO_BITS;

   typedef struct packed {
      logic [31:0] r;
      logic [31:0] ml;
      logic [31:0] q;
   } div_type;

   function automatic logic signed [31:0] sat32(input logic signed [42:0] v);
      if (v > 43'sd2147483647)
         return 32'sh7FFFFFFF;
      else if (v < -43'sd2147483648)
         return 32'sh80000000;
      else
         return v[31:0];
   endfunction

   logic adv;
   req_payload_type rq;

   // stage 1
   logic v1_ff;
   ctx_type ctx1_ff, ctx1_in;
   logic signed [31:0] tgt1_ff;
   logic signed [32:0] d1_ff [3];
   // stage 2
   logic v2_ff;
   ctx_type ctx2_ff;
   logic signed [31:0] tgt2_ff;
   logic signed [48:0] p2_ff [3];
   // stage 3
   logic v3_ff;
   ctx_type ctx3_ff;
   logic signed [31:0] tgt3_ff;
   logic signed [50:0] acc3_ff;
   // stage 4
   logic v4_ff, neg4_ff, kz4_ff, sat4_ff;
   logic neg4_in, kz4_in, sat4_in;
   ctx_type ctx4_ff;
   logic [M_W-1:0] m4_ff, m4_in;
   // divider
   logic    vd_ff [DIV_N];
   logic    negd_ff [DIV_N];
   logic    kzd_ff [DIV_N];
   logic    satd_ff [DIV_N];
   ctx_type ctxd_ff [DIV_N];
   div_type dv_ff [DIV_N];
   div_type dv_in [DIV_N];
   // clamp stage
   logic vj_ff, kzj_ff;
   ctx_type ctxj_ff;
   logic [30:0] jn1j_ff, jn1j_in;
   logic signed [31:0] djapj_ff, djapj_in;
   // impulse product stage
   logic vp_ff, kzp_ff;
   ctx_type ctxp_ff;
   logic [30:0] jn1p_ff;
   logic signed [47:0] prdp_ff [3];
   // impulse magnitude stage
   logic vi_ff, kzi_ff;
   ctx_type ctxi_ff;
   logic [30:0] jn1i_ff;
   logic [32:0] imagi_ff [3];
   logic        inegi_ff [3];
   // partial product stage
   logic vm_ff, kzm_ff;
   ctx_type ctxm_ff;
   logic [30:0] jn1m_ff;
   logic [48:0] pha_ff [3], pla_ff [3], phb_ff [3], plb_ff [3];
   logic        inegm_ff [3];
   // velocity change stage
   logic vq_ff, kzq_ff;
   ctx_type ctxq_ff;
   logic [30:0] jn1q_ff;
   logic [40:0] qa_ff [3], qb_ff [3];
   logic [40:0] qa_in [3], qb_in [3];
   logic        inegq_ff [3];
   // output
   logic out_v_ff;
   rsp_payload_type out_ff, out_in;

   assign rq = req_chan.payload;
   assign adv = !out_v_ff || rsp_chan.ready;
   assign req_chan.ready = adv;
   assign rsp_chan.valid = out_v_ff;
   assign rsp_chan.payload = out_ff;

   always_comb begin
      ctx1_in.n    = rq.contact_normal;
      ctx1_in.va   = {rq.a_vel_z, rq.a_vel_y, rq.a_vel_x};
      ctx1_in.vb   = {rq.b_vel_z, rq.b_vel_y, rq.b_vel_x};
      ctx1_in.k    = rq.mass_denominator;
      ctx1_in.jn0  = rq.accumulated_impulse;
      ctx1_in.ima  = rq.inverse_masses[31:0];
      ctx1_in.imb  = rq.inverse_masses[63:32];
      ctx1_in.last = rq.last_contact;
   end

   // stage 4 combinational: numerator, magnitude, overflow test
   always_comb begin
      logic [50:0]        amag;
      logic signed [37:0] shr;
      logic signed [37:0] num;
      logic [37:0]        nmag;
      amag    = acc3_ff[50] ? 51'(-acc3_ff) : 51'(acc3_ff);
      shr     = acc3_ff[50] ? -$signed({1'b0, 37'(amag >> NORMAL_FRAC)})
                            : $signed({1'b0, 37'(amag >> NORMAL_FRAC)});
      num     = 38'(tgt3_ff) - shr;
      nmag    = num[37] ? 38'(-num) : 38'(num);
      neg4_in = num[37];
      m4_in   = M_W'(nmag) << FRAC_BITS;
      kz4_in  = (ctx3_ff.k == '0);
      sat4_in = 64'(m4_in) >= {1'b0, ctx3_ff.k, 32'b0};
   end

   // restoring divider, one quotient bit a stage
   for (genvar gi = 0; gi < DIV_N; gi++) begin : g_div
      div_type src_dv;
      ctx_type src_ctx;
      logic    src_v, src_neg, src_kz, src_sat;

      if (gi == 0) begin : g_head
         assign src_dv.r  = 32'(m4_ff >> 32);
         assign src_dv.ml = m4_ff[31:0];
         assign src_dv.q  = '0;
         assign src_ctx   = ctx4_ff;
         assign src_v     = v4_ff;
         assign src_neg   = neg4_ff;
         assign src_kz    = kz4_ff;
         assign src_sat   = sat4_ff;
      end else begin : g_body
         assign src_dv  = dv_ff[gi-1];
         assign src_ctx = ctxd_ff[gi-1];
         assign src_v   = vd_ff[gi-1];
         assign src_neg = negd_ff[gi-1];
         assign src_kz  = kzd_ff[gi-1];
         assign src_sat = satd_ff[gi-1];
      end

      always_comb begin
         logic [32:0] r2;
         r2 = {src_dv.r, src_dv.ml[31]};
         dv_in[gi].ml = {src_dv.ml[30:0], 1'b0};
         if (r2 >= 33'(src_ctx.k)) begin
            dv_in[gi].r = 32'(r2 - 33'(src_ctx.k));
            dv_in[gi].q = {src_dv.q[30:0], 1'b1};
         end else begin
            dv_in[gi].r = r2[31:0];
            dv_in[gi].q = {src_dv.q[30:0], 1'b0};
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            vd_ff[gi] <= 1'b0;
         end else if (adv) begin
            vd_ff[gi] <= src_v;
         end
         if (adv) begin
            dv_ff[gi]   <= dv_in[gi];
            ctxd_ff[gi] <= src_ctx;
            negd_ff[gi] <= src_neg;
            kzd_ff[gi]  <= src_kz;
            satd_ff[gi] <= src_sat;
         end
      end
   end

   // clamp accumulated impulse, form applied change
   always_comb begin
      logic [32:0]        qmag;
      logic signed [33:0] dj;
      logic signed [34:0] jsum;
      if (kzd_ff[DIV_N-1])
         qmag = '0;
      else if (satd_ff[DIV_N-1])
         qmag = 33'h1_0000_0000;
      else
         qmag = {1'b0, dv_ff[DIV_N-1].q};
      dj   = negd_ff[DIV_N-1] ? -$signed({1'b0, qmag}) : $signed({1'b0, qmag});
      jsum = $signed({4'b0, ctxd_ff[DIV_N-1].jn0}) + 35'(dj);
      if (jsum < 0)
         jn1j_in = '0;
      else if (jsum > 35'sd2147483647)
         jn1j_in = 31'h7FFFFFFF;
      else
         jn1j_in = jsum[30:0];
      djapj_in = $signed({1'b0, jn1j_in}) - $signed({1'b0, ctxd_ff[DIV_N-1].jn0});
   end

   // velocity change with cap
   always_comb begin
      logic [65:0] sa, sb;
      logic [65:0] sha, shb;
      for (int i = 0; i < 3; i++) begin
         sa  = {1'b0, pha_ff[i], 16'b0} + 66'(pla_ff[i]);
         sb  = {1'b0, phb_ff[i], 16'b0} + 66'(plb_ff[i]);
         sha = sa >> FRAC_BITS;
         shb = sb >> FRAC_BITS;
         qa_in[i] = (pha_ff[i] >= 49'(64'h4000_0000_0000) || sha > 66'(64'h100_0000_0000))
                    ? 41'h100_0000_0000 : sha[40:0];
         qb_in[i] = (phb_ff[i] >= 49'(64'h4000_0000_0000) || shb > 66'(64'h100_0000_0000))
                    ? 41'h100_0000_0000 : shb[40:0];
      end
   end

   always_comb begin
      logic signed [42:0] sqa, sqb;
      logic signed [31:0] na [3];
      logic signed [31:0] nb [3];
      for (int i = 0; i < 3; i++) begin
         sqa   = inegq_ff[i] ? -$signed({2'b0, qa_ff[i]}) : $signed({2'b0, qa_ff[i]});
         sqb   = inegq_ff[i] ? -$signed({2'b0, qb_ff[i]}) : $signed({2'b0, qb_ff[i]});
         na[i] = sat32(43'($signed(ctxq_ff.va[i])) - sqa);
         nb[i] = sat32(43'($signed(ctxq_ff.vb[i])) + sqb);
      end
      out_in.new_a_vel_x = na[0];
      out_in.new_a_vel_y = na[1];
      out_in.new_a_vel_z = na[2];
      out_in.new_b_vel_x = nb[0];
      out_in.new_b_vel_y = nb[1];
      out_in.new_b_vel_z = nb[2];
      out_in.new_accumulated_impulse = jn1q_ff;
      out_in.zero_denominator = kzq_ff;
      out_in.last_contact_out = ctxq_ff.last;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff    <= 1'b0;
         v2_ff    <= 1'b0;
         v3_ff    <= 1'b0;
         v4_ff    <= 1'b0;
         vj_ff    <= 1'b0;
         vp_ff    <= 1'b0;
         vi_ff    <= 1'b0;
         vm_ff    <= 1'b0;
         vq_ff    <= 1'b0;
         out_v_ff <= 1'b0;
      end else if (adv) begin
         v1_ff    <= req_chan.valid;
         v2_ff    <= v1_ff;
         v3_ff    <= v2_ff;
         v4_ff    <= v3_ff;
         vj_ff    <= vd_ff[DIV_N-1];
         vp_ff    <= vj_ff;
         vi_ff    <= vp_ff;
         vm_ff    <= vi_ff;
         vq_ff    <= vm_ff;
         out_v_ff <= vq_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         ctx1_ff <= ctx1_in;
         tgt1_ff <= rq.target_normal_velocity;
         for (int i = 0; i < 3; i++) begin
            d1_ff[i] <= 33'($signed(ctx1_in.vb[i])) - 33'($signed(ctx1_in.va[i]));
         end

         ctx2_ff <= ctx1_ff;
         tgt2_ff <= tgt1_ff;
         for (int i = 0; i < 3; i++) begin
            p2_ff[i] <= 49'(d1_ff[i]) * 49'($signed(ctx1_ff.n[i]));
         end

         ctx3_ff <= ctx2_ff;
         tgt3_ff <= tgt2_ff;
         acc3_ff <= 51'(p2_ff[0]) + 51'(p2_ff[1]) + 51'(p2_ff[2]);

         ctx4_ff <= ctx3_ff;
         m4_ff   <= m4_in;
         neg4_ff <= neg4_in;
         kz4_ff  <= kz4_in;
         sat4_ff <= sat4_in;

         ctxj_ff  <= ctxd_ff[DIV_N-1];
         kzj_ff   <= kzd_ff[DIV_N-1];
         jn1j_ff  <= jn1j_in;
         djapj_ff <= djapj_in;

         ctxp_ff <= ctxj_ff;
         kzp_ff  <= kzj_ff;
         jn1p_ff <= jn1j_ff;
         for (int i = 0; i < 3; i++) begin
            prdp_ff[i] <= 48'(djapj_ff) * 48'($signed(ctxj_ff.n[i]));
         end

         ctxi_ff <= ctxp_ff;
         kzi_ff  <= kzp_ff;
         jn1i_ff <= jn1p_ff;
         for (int i = 0; i < 3; i++) begin
            imagi_ff[i] <= 33'((prdp_ff[i][47] ? 48'(-prdp_ff[i]) : 48'(prdp_ff[i]))
                               >> NORMAL_FRAC);
            inegi_ff[i] <= prdp_ff[i][47];
         end

         ctxm_ff <= ctxi_ff;
         kzm_ff  <= kzi_ff;
         jn1m_ff <= jn1i_ff;
         for (int i = 0; i < 3; i++) begin
            pha_ff[i]   <= 49'(ctxi_ff.ima[31:16]) * 49'(imagi_ff[i]);
            pla_ff[i]   <= 49'(ctxi_ff.ima[15:0])  * 49'(imagi_ff[i]);
            phb_ff[i]   <= 49'(ctxi_ff.imb[31:16]) * 49'(imagi_ff[i]);
            plb_ff[i]   <= 49'(ctxi_ff.imb[15:0])  * 49'(imagi_ff[i]);
            inegm_ff[i] <= inegi_ff[i];
         end

         ctxq_ff <= ctxm_ff;
         kzq_ff  <= kzm_ff;
         jn1q_ff <= jn1m_ff;
         for (int i = 0; i < 3; i++) begin
            qa_ff[i]    <= qa_in[i];
            qb_ff[i]    <= qb_in[i];
            inegq_ff[i] <= inegm_ff[i];
         end

         out_ff <= out_in;
      end
   end

   a_rem_below_k: assert property (@(posedge clock) disable iff (reset)
      (vd_ff[DIV_N-1] && !kzd_ff[DIV_N-1] && !satd_ff[DIV_N-1])
      |-> (dv_ff[DIV_N-1].r < 32'(ctxd_ff[DIV_N-1].k)))
      else $error("divider remainder not below denominator");

   a_zero_k_passes: assert property (@(posedge clock) disable iff (reset)
      (out_v_ff && out_ff.zero_denominator && $past(adv))
      |-> (out_ff.new_a_vel_x == $past(ctxq_ff.va[0])))
      else $error("velocity changed with zero denominator");

   a_zero_k_change: assert property (@(posedge clock) disable iff (reset)
      (vj_ff && kzj_ff) |-> (djapj_ff == '0))
      else $error("impulse applied with zero denominator");

   a_reset_empty: assert property (@(posedge clock)
      $past(reset) |-> !rsp_chan.valid)
      else $error("result valid straight after reset");

endmodule
